// ===== design/mfau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mfau_pkg;

    localparam int ID_W        = 11;
    localparam int WORD_W      = 16;
    localparam int SLOT_W      = 3;
    localparam int TURN_W      = 24;
    localparam int TOTAL_W     = 38;
    localparam int TURN_SHIFT  = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_ID_REGS = 7;

    localparam logic [ID_W-1:0]     BASE_ID  = 11'd513;
    localparam logic [WORD_W:0]     JUMP_POS = 17'sd4096;
    localparam logic [WORD_W:0]     JUMP_NEG = -17'sd4096;
    localparam logic [TURN_W-1:0]   TURN_MAX = 24'h7F_FFFF;
    localparam logic [TURN_W-1:0]   TURN_MIN = 24'h80_0000;

    // Frame that matched a slot, handed from the classifier to the update stage.
    typedef struct packed {
        logic [SLOT_W-1:0]        slot;
        logic signed [WORD_W-1:0] angle;
        logic signed [WORD_W-1:0] speed;
        logic signed [WORD_W-1:0] current;
    } t_cls_item;

endpackage

`default_nettype wire

// ===== design/mfau_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mfau_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  bus_index;
    logic [mfau_pkg::ID_W-1:0]             frame_id;
    logic signed [mfau_pkg::WORD_W-1:0]    angle_word;
    logic signed [mfau_pkg::WORD_W-1:0]    speed_word;
    logic signed [mfau_pkg::WORD_W-1:0]    current_word;

    modport source (
        output valid, bus_index, frame_id, angle_word, speed_word, current_word,
        input  ready
    );
    modport sink (
        input  valid, bus_index, frame_id, angle_word, speed_word, current_word,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/mfau_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mfau_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [mfau_pkg::SLOT_W-1:0]           motor_slot;
    logic signed [mfau_pkg::WORD_W-1:0]    angle_now;
    logic signed [mfau_pkg::WORD_W-1:0]    speed_now;
    logic signed [mfau_pkg::WORD_W-1:0]    current_now;
    logic signed [mfau_pkg::TURN_W-1:0]    turn_count;
    logic signed [mfau_pkg::TOTAL_W-1:0]   multiturn_angle;
    logic signed [mfau_pkg::WORD_W-1:0]    first_angle;

    modport source (
        output valid, motor_slot, angle_now, speed_now, current_now, turn_count,
               multiturn_angle, first_angle,
        input  ready
    );
    modport sink (
        input  valid, motor_slot, angle_now, speed_now, current_now, turn_count,
               multiturn_angle, first_angle,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/mfau_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mfau_front #(
    parameter int NUM_SLOTS = 7
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    mfau_in_if.sink                          i_frame,
    input  wire                              i_cfg_we,
    input  wire [mfau_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [mfau_pkg::ID_W-1:0]         i_cfg_data,
    output logic                             o_push_valid,
    output mfau_pkg::t_cls_item              o_push_item,
    input  wire                              i_push_ready
);

    logic [mfau_pkg::ID_W-1:0]   r_slot_id [NUM_SLOTS];
    logic                        hit;
    logic [mfau_pkg::SLOT_W-1:0] hit_slot;

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_id
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_slot_id[k] <= mfau_pkg::ID_W'(mfau_pkg::BASE_ID + k);
            end else if (i_cfg_we && (k < mfau_pkg::NUM_ID_REGS)
                         && (i_cfg_index == mfau_pkg::CFG_IDX_W'(k))) begin
                r_slot_id[k] <= i_cfg_data;
            end
        end
    end

    // The lowest-numbered matching slot wins.
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (r_slot_id[k] == i_frame.frame_id) begin
                hit      = 1'b1;
                hit_slot = mfau_pkg::SLOT_W'(k);
            end
        end
    end

    assign i_frame.ready       = i_push_ready;
    assign o_push_valid        = i_frame.valid && i_push_ready && !i_frame.bus_index && hit;
    assign o_push_item.slot    = hit_slot;
    assign o_push_item.angle   = i_frame.angle_word;
    assign o_push_item.speed   = i_frame.speed_word;
    assign o_push_item.current = i_frame.current_word;

`ifndef SYNTHESIS
    a_ignored_bus_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_frame.valid && i_frame.ready && i_frame.bus_index) |-> !o_push_valid)
        else $error("frame from the ignored bus was queued");
`endif

endmodule

`default_nettype wire

// ===== design/mfau_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mfau_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push_valid,
    input  mfau_pkg::t_cls_item   i_push_item,
    output logic                  o_push_ready,
    output logic                  o_pop_valid,
    output mfau_pkg::t_cls_item   o_pop_item,
    input  wire                   i_pop_ready
);

    localparam int Depth = 2;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    mfau_pkg::t_cls_item r_mem [Depth];
    logic [PtrW-1:0]     r_wr_ptr;
    logic [PtrW-1:0]     r_rd_ptr;
    logic [CntW-1:0]     r_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count != CntW'(Depth));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(Depth))
        else $error("queue fill count beyond its depth");
`endif

endmodule

`default_nettype wire

// ===== design/mfau_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mfau_back #(
    parameter int NUM_SLOTS = 7
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_pop_valid,
    input  mfau_pkg::t_cls_item   i_pop_item,
    output logic                  o_pop_ready,
    mfau_out_if.source            o_result
);

    localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic signed [mfau_pkg::WORD_W-1:0]  r_prev  [NUM_SLOTS];
    logic signed [mfau_pkg::TURN_W-1:0]  r_turns [NUM_SLOTS];
    logic signed [mfau_pkg::WORD_W-1:0]  r_start [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]                r_seen;

    logic                                r_out_valid;
    logic [mfau_pkg::SLOT_W-1:0]         r_slot;
    logic signed [mfau_pkg::WORD_W-1:0]  r_angle;
    logic signed [mfau_pkg::WORD_W-1:0]  r_speed;
    logic signed [mfau_pkg::WORD_W-1:0]  r_current;
    logic signed [mfau_pkg::TURN_W-1:0]  r_turn_count;
    logic signed [mfau_pkg::TOTAL_W-1:0] r_total;
    logic signed [mfau_pkg::WORD_W-1:0]  r_first;

    logic                                pop;
    logic [IdxW-1:0]                     idx;
    logic signed [mfau_pkg::WORD_W:0]    diff;
    logic signed [mfau_pkg::TURN_W-1:0]  cur_turns;
    logic signed [mfau_pkg::TURN_W-1:0]  n_turns;
    logic signed [mfau_pkg::TOTAL_W-1:0] n_total;
    logic signed [mfau_pkg::WORD_W-1:0]  n_first;

    assign o_pop_ready = !r_out_valid || o_result.ready;
    assign pop         = i_pop_valid && o_pop_ready;
    assign idx         = i_pop_item.slot[IdxW-1:0];
    assign cur_turns   = r_turns[idx];

    always_comb begin
        diff = {i_pop_item.angle[mfau_pkg::WORD_W-1], i_pop_item.angle}
             - {r_prev[idx][mfau_pkg::WORD_W-1], r_prev[idx]};
        n_turns = cur_turns;
        if (diff > $signed(mfau_pkg::JUMP_POS)) begin
            if (cur_turns != mfau_pkg::TURN_MIN) begin
                n_turns = cur_turns - 1'b1;
            end
        end else if (diff < $signed(mfau_pkg::JUMP_NEG)) begin
            if (cur_turns != mfau_pkg::TURN_MAX) begin
                n_turns = cur_turns + 1'b1;
            end
        end
        n_total = {n_turns[mfau_pkg::TURN_W-1], n_turns, mfau_pkg::TURN_SHIFT'(0)}
                + {{(mfau_pkg::TOTAL_W - mfau_pkg::WORD_W){i_pop_item.angle[mfau_pkg::WORD_W-1]}},
                   i_pop_item.angle};
        n_first = r_seen[idx] ? r_start[idx] : i_pop_item.angle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_prev[k]  <= '0;
                r_turns[k] <= '0;
                r_start[k] <= '0;
            end
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_prev[idx]  <= i_pop_item.angle;
                r_turns[idx] <= n_turns;
                if (!r_seen[idx]) begin
                    r_start[idx] <= i_pop_item.angle;
                    r_seen[idx]  <= 1'b1;
                end
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_slot       <= i_pop_item.slot;
            r_angle      <= i_pop_item.angle;
            r_speed      <= i_pop_item.speed;
            r_current    <= i_pop_item.current;
            r_turn_count <= n_turns;
            r_total      <= n_total;
            r_first      <= n_first;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.motor_slot      = r_slot;
    assign o_result.angle_now       = r_angle;
    assign o_result.speed_now       = r_speed;
    assign o_result.current_now     = r_current;
    assign o_result.turn_count      = r_turn_count;
    assign o_result.multiturn_angle = r_total;
    assign o_result.first_angle     = r_first;

`ifndef SYNTHESIS
    a_total_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_total == ({r_turn_count[mfau_pkg::TURN_W-1], r_turn_count,
                                      mfau_pkg::TURN_SHIFT'(0)}
            + {{(mfau_pkg::TOTAL_W - mfau_pkg::WORD_W){r_angle[mfau_pkg::WORD_W-1]}},
               r_angle})))
        else $error("total angle does not match turn count and angle");

    a_slot_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> r_seen[$past(idx)])
        else $error("updated slot not marked as started");

    a_turns_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_turns[$past(idx)] == r_turn_count))
        else $error("stored turn count differs from the delivered one");
`endif

endmodule

`default_nettype wire

// ===== design/motor_feedback_angle_unwrap_top.sv =====
// Motor feedback decoder with multi-turn angle unwrapping.
// Frames enter on i_frame (valid/ready); a transfer happens when both are high.
// Frames from bus 1, and frames whose identifier matches no slot, are consumed
// and produce nothing. A matching frame yields one transfer on o_result with the
// slot index, the decoded words, the updated turn count, the total angle and the
// angle latched from the slot's first frame.
// Slot identifiers are to be written through i_cfg_we, i_cfg_index and i_cfg_data
// by the user while the block is idle; the block does not enforce this. Indexes
// of seven or more are ignored. A frame is written into the queue, from which the
// update stage reads it and registers its result.
// Throughput: one frame per cycle while the receiver holds ready high, set by the
// slot update stage that reads and writes the per-slot angle and turn registers.
// A two-entry queue separates identifier matching from the update stage, and the
// result register lets a new frame enter while a result waits; when the receiver
// holds ready low the queue fills and i_frame.ready drops two frames later.
// Reset clears all slot state and restores identifiers 0x201 upward.
`timescale 1ns / 1ps
`default_nettype none

module motor_feedback_angle_unwrap_top #(
    parameter int NUM_SLOTS = 7
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    mfau_in_if.sink                          i_frame,
    mfau_out_if.source                       o_result,
    input  wire                              i_cfg_we,
    input  wire [mfau_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [mfau_pkg::ID_W-1:0]         i_cfg_data
);

    logic                push_valid;
    logic                push_ready;
    mfau_pkg::t_cls_item push_item;
    logic                pop_valid;
    logic                pop_ready;
    mfau_pkg::t_cls_item pop_item;

    mfau_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame      (i_frame),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    mfau_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_item   (pop_item),
        .i_pop_ready  (pop_ready)
    );

    mfau_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_item  (pop_item),
        .o_pop_ready (pop_ready),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// ===== tb/sv/motor_feedback_angle_unwrap_top_tb.sv =====
`timescale 1ns / 1ps

module motor_feedback_angle_unwrap_top_tb;
    import mfau_pkg::*;

    localparam int NUM_SLOTS  = 7;
    localparam int JUMP_LIMIT = 4096;
    localparam int HOLD_LEN   = 80;
    localparam int DRAIN_WAIT = 4;

    typedef struct packed {
        logic                     bus;
        logic [ID_W-1:0]          id;
        logic signed [WORD_W-1:0] ang;
        logic signed [WORD_W-1:0] spd;
        logic signed [WORD_W-1:0] cur;
    } frame_t;

    typedef struct packed {
        logic [SLOT_W-1:0]         slot;
        logic signed [WORD_W-1:0]  ang;
        logic signed [WORD_W-1:0]  spd;
        logic signed [WORD_W-1:0]  cur;
        logic signed [TURN_W-1:0]  turns;
        logic signed [TOTAL_W-1:0] total;
        logic signed [WORD_W-1:0]  start;
    } unwrap_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [ID_W-1:0]       cfg_data;

    mfau_in_if  fr_if();
    mfau_out_if res_if();

    motor_feedback_angle_unwrap_top #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame     (fr_if),
        .o_result    (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Predictor state, one entry per motor slot.
    logic [ID_W-1:0]          slot_ids        [NUM_SLOTS];
    logic signed [WORD_W-1:0] last_seen_angle [NUM_SLOTS];
    logic signed [TURN_W-1:0] turn_cnt        [NUM_SLOTS];
    logic signed [WORD_W-1:0] latched_angle   [NUM_SLOTS];
    logic                     start_valid     [NUM_SLOTS];

    // Last angle sent per identifier, used to aim frames at the jump thresholds.
    logic signed [WORD_W-1:0] sent_angle [2048];

    frame_t  pending_frames[$];
    unwrap_t pending_results[$];
    int      frames_queued;
    int      frames_taken;
    int      mismatch_count;
    bit      idle_on;
    logic    rx_hold;
    int      tx_gap;
    int      rx_gap;
    frame_t  next_frame;
    frame_t  taken_frame;
    unwrap_t taken_result;
    event    rx_hold_ev;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic bit unwrap_frame(input frame_t f, output unwrap_t r);
        int     hit;
        int     jump;
        longint total;
        hit = -1;
        r = '0;
        if (f.bus) return 1'b0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (slot_ids[k] == f.id) hit = k;
        end
        if (hit < 0) return 1'b0;
        jump = int'(f.ang) - int'(last_seen_angle[hit]);
        last_seen_angle[hit] = f.ang;
        if (!start_valid[hit]) begin
            latched_angle[hit] = f.ang;
            start_valid[hit] = 1'b1;
        end
        if (jump > JUMP_LIMIT) begin
            if (turn_cnt[hit] != $signed(TURN_MIN)) turn_cnt[hit] = turn_cnt[hit] - 1;
        end else if (jump < -JUMP_LIMIT) begin
            if (turn_cnt[hit] != $signed(TURN_MAX)) turn_cnt[hit] = turn_cnt[hit] + 1;
        end
        total = longint'(turn_cnt[hit]) * (longint'(1) << TURN_SHIFT) + longint'(f.ang);
        r.slot  = hit[SLOT_W-1:0];
        r.ang   = f.ang;
        r.spd   = f.spd;
        r.cur   = f.cur;
        r.turns = turn_cnt[hit];
        r.total = total[TOTAL_W-1:0];
        r.start = latched_angle[hit];
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [TOTAL_W-1:0] got,
                               input logic [TOTAL_W-1:0] want);
        if (got !== want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task automatic check_result();
        unwrap_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
        end else begin
            want = pending_results.pop_front();
            check_field("motor_slot", res_if.motor_slot, want.slot);
            check_field("angle_now", res_if.angle_now, want.ang);
            check_field("speed_now", res_if.speed_now, want.spd);
            check_field("current_now", res_if.current_now, want.cur);
            check_field("turn_count", res_if.turn_count, want.turns);
            check_field("multiturn_angle", res_if.multiturn_angle, want.total);
            check_field("first_angle", res_if.first_angle, want.start);
        end
    endtask

    // Frame driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fr_if.valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (fr_if.valid && fr_if.ready) begin
                taken_frame.bus = fr_if.bus_index;
                taken_frame.id  = fr_if.frame_id;
                taken_frame.ang = fr_if.angle_word;
                taken_frame.spd = fr_if.speed_word;
                taken_frame.cur = fr_if.current_word;
                if (unwrap_frame(taken_frame, taken_result)) pending_results.push_back(taken_result);
                frames_taken++;
            end
            if (!fr_if.valid || fr_if.ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    fr_if.valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 5) == 0) begin
                    tx_gap = $urandom_range(0, 9);
                    fr_if.valid <= 1'b0;
                end else if (pending_frames.size() != 0) begin
                    next_frame = pending_frames.pop_front();
                    fr_if.valid        <= 1'b1;
                    fr_if.bus_index    <= next_frame.bus;
                    fr_if.frame_id     <= next_frame.id;
                    fr_if.angle_word   <= next_frame.ang;
                    fr_if.speed_word   <= next_frame.spd;
                    fr_if.current_word <= next_frame.cur;
                end else begin
                    fr_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (res_if.valid && res_if.ready) check_result();
            if (rx_hold) begin
                res_if.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                res_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                rx_gap = $urandom_range(0, 9);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off, so that the block fills up and stalls its input.
    initial begin
        rx_hold = 1'b0;
        forever begin
            @(rx_hold_ev);
            @(posedge i_clk);
            rx_hold <= 1'b1;
            repeat (HOLD_LEN) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    task automatic queue_frame(input bit bus, input int id, input int ang, input int spd,
                               input int cur);
        frame_t f;
        f.bus = bus;
        f.id  = id[ID_W-1:0];
        f.ang = ang[WORD_W-1:0];
        f.spd = spd[WORD_W-1:0];
        f.cur = cur[WORD_W-1:0];
        if (!bus) sent_angle[f.id] = f.ang;
        pending_frames.push_back(f);
        frames_queued++;
    endtask

    task automatic queue_random_frames(input int count);
        bit                       bus;
        logic [ID_W-1:0]          id;
        logic signed [WORD_W-1:0] raw;
        int                       ang;
        repeat (count) begin
            bus = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 4) == 0) id = $urandom_range(0, 2047);
            else id = slot_ids[$urandom_range(0, NUM_SLOTS - 1)];
            raw = $urandom;
            case ($urandom_range(0, 3))
                0, 1: ang = raw;
                2: ang = sent_angle[id] + ($urandom_range(0, 1) ? 1 : -1)
                         * int'($urandom_range(JUMP_LIMIT - 1, JUMP_LIMIT + 1));
                default: ang = sent_angle[id] + int'($urandom_range(0, 200)) - 100;
            endcase
            queue_frame(bus, id, ang, $urandom, $urandom);
        end
    endtask

    task automatic cfg_write(input int idx, input int data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data  <= data[ID_W-1:0];
        if (idx < NUM_ID_REGS && idx < NUM_SLOTS) slot_ids[idx] = data[ID_W-1:0];
    endtask

    task automatic cfg_finish();
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (frames_taken != frames_queued || pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        fr_if.valid         = 1'b0;
        fr_if.bus_index     = 1'b0;
        fr_if.frame_id      = '0;
        fr_if.angle_word    = '0;
        fr_if.speed_word    = '0;
        fr_if.current_word  = '0;
        res_if.ready        = 1'b0;
        frames_queued       = 0;
        frames_taken        = 0;
        mismatch_count      = 0;
        idle_on             = 1'b0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            slot_ids[k]        = BASE_ID + ID_W'(k);
            last_seen_angle[k] = '0;
            turn_cnt[k]        = '0;
            latched_angle[k]   = '0;
            start_valid[k]     = 1'b0;
        end
        for (int k = 0; k < 2048; k++) sent_angle[k] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset identifiers: first frames on either side of the jump limit,
        // field extremes, the ignored bus and unmatched identifiers.
        queue_frame(0, BASE_ID + 0, 5000, 1, -1);
        queue_frame(0, BASE_ID + 1, -5000, -1, 1);
        queue_frame(0, BASE_ID + 2, 4096, 0, 0);
        queue_frame(0, BASE_ID + 3, -4096, 0, 0);
        queue_frame(0, BASE_ID + 4, 32767, -32768, 32767);
        queue_frame(0, BASE_ID + 5, -32768, 32767, -32768);
        queue_frame(0, BASE_ID + 6, 0, 0, 0);
        queue_frame(1, BASE_ID + 0, 12345, 7, 7);
        queue_frame(0, 0, 100, 100, 100);
        queue_frame(0, 2047, 100, 100, 100);
        queue_frame(1, 2047, -1, -1, -1);
        queue_frame(0, BASE_ID + 0, 100, 2, 2);
        queue_frame(0, BASE_ID + 0, 4197, 3, 3);
        queue_frame(0, BASE_ID + 0, 101, 4, 4);
        queue_frame(0, BASE_ID + 0, 4197, 5, 5);
        queue_frame(0, BASE_ID + 0, 32767, 6, 6);
        queue_frame(0, BASE_ID + 0, -32768, 7, 7);
        queue_frame(0, BASE_ID + 0, 32767, 8, 8);
        queue_frame(0, BASE_ID + 4, -32768, 9, 9);
        wait_idle();

        // Identifier extremes, a duplicate pair and a write past the last register.
        cfg_write(0, 2047);
        cfg_write(1, 0);
        cfg_write(2, 'h300);
        cfg_write(3, 'h155);
        cfg_write(4, 'h2AA);
        cfg_write(5, 'h300);
        cfg_write(6, BASE_ID);
        cfg_write(7, 'h123);
        cfg_finish();
        queue_frame(0, 2047, -20000, 11, 11);
        queue_frame(0, 0, 20000, 12, 12);
        queue_frame(0, 'h300, 3000, 13, 13);
        queue_frame(0, 'h123, 3000, 14, 14);
        queue_frame(0, BASE_ID, -9000, 15, 15);
        idle_on = 1'b1;
        queue_random_frames(170);
        wait_idle();

        // Receiver holds off while frames keep coming.
        idle_on = 1'b0;
        -> rx_hold_ev;
        queue_random_frames(40);
        wait_idle();

        for (int k = 0; k < 8; k++) cfg_write(k, $urandom_range(0, 2047));
        cfg_finish();
        idle_on = 1'b1;
        queue_random_frames(170);
        wait_idle();

        // Crowded identifier range for frequent duplicates; no idling from here on.
        idle_on = 1'b0;
        for (int k = 0; k < 8; k++) cfg_write(k, $urandom_range(BASE_ID - 1, BASE_ID + 6));
        cfg_finish();
        queue_random_frames(170);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
